// ===== design/compressed_pointer_log_macros.svh =====
`ifndef COMPRESSED_POINTER_LOG_MACROS_SVH
`define COMPRESSED_POINTER_LOG_MACROS_SVH

// same-cycle implication
`define CPL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CPL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/cpl_pkg.sv =====
`timescale 1ns / 1ps

package cpl_pkg;

    localparam int LOG_DEPTH    = 64;
    localparam int SLOT_BITS    = $clog2(LOG_DEPTH);
    localparam int COUNT_BITS   = $clog2(LOG_DEPTH + 1);
    localparam int LOOKBEHIND   = 4;
    localparam int LB_BITS      = $clog2(LOOKBEHIND + 1);
    localparam int ADDRESS_BITS = 48;
    localparam int BYTE_BITS    = 8;
    localparam int PREFIX_BITS  = ADDRESS_BITS - BYTE_BITS;
    localparam int ENTRY_BITS   = PREFIX_BITS + 3 * BYTE_BITS;
    localparam int THR_BITS     = 7;
    localparam int OUTCOME_BITS = 3;
    localparam int NRET_BITS    = 2;

    localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(64);

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_POP    = 1'b1;

    localparam logic [OUTCOME_BITS-1:0] OC_DUPLICATE = 3'd0;
    localparam logic [OUTCOME_BITS-1:0] OC_MERGED    = 3'd1;
    localparam logic [OUTCOME_BITS-1:0] OC_NEW_SLOT  = 3'd2;
    localparam logic [OUTCOME_BITS-1:0] OC_POPPED    = 3'd3;
    localparam logic [OUTCOME_BITS-1:0] OC_EMPTY     = 3'd4;

    typedef struct packed {
        logic                    kind;
        logic [ADDRESS_BITS-1:0] pointer_address;
    } t_req;

    typedef struct packed {
        logic [OUTCOME_BITS-1:0] outcome;
        logic [SLOT_BITS-1:0]    slot;
        logic [COUNT_BITS-1:0]   live_slots;
        logic [ADDRESS_BITS-1:0] first_pointer;
        logic [ADDRESS_BITS-1:0] second_pointer;
        logic [ADDRESS_BITS-1:0] third_pointer;
        logic [NRET_BITS-1:0]    pointers_returned;
        logic                    over_threshold;
    } t_rsp;

endpackage

// ===== design/cpl_req_if.sv =====
`timescale 1ns / 1ps

interface cpl_req_if import cpl_pkg::*;;
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/cpl_rsp_if.sv =====
`timescale 1ns / 1ps

interface cpl_rsp_if import cpl_pkg::*;;
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== design/compressed_pointer_log.sv =====
`timescale 1ns / 1ps
// order: an insert reads back up to min(4, live slots) slots in S_SCAN, stopping at a
//   duplicate, then writes back in S_FIN; a pop reads the oldest slot and goes to S_FIN
// throughput: one request at a time, set by one slot read per cycle from the single-port
//   log memory, the final write-back and back-pressure on the response
// reset: synchronous active-low; slot pointers and the live count clear, threshold goes to 64,
//   log memory contents are not cleared
`include "compressed_pointer_log_macros.svh"

module compressed_pointer_log import cpl_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [THR_BITS-1:0] i_cfg_wdata,
    cpl_req_if.sink             i_req,
    cpl_rsp_if.source           o_rsp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [ENTRY_BITS-1:0] r_mem [LOG_DEPTH];
    logic [ENTRY_BITS-1:0] r_rd_data;

    logic [1:0]             r_state, n_state;
    logic [SLOT_BITS-1:0]   r_write_slot, n_write_slot;
    logic [SLOT_BITS-1:0]   r_oldest, n_oldest;
    logic [COUNT_BITS-1:0]  r_live, n_live;
    logic [THR_BITS-1:0]    r_thr;
    logic                   r_kind, n_kind;
    logic [PREFIX_BITS-1:0] r_prefix, n_prefix;
    logic [BYTE_BITS-1:0]   r_byte, n_byte;
    logic [LB_BITS-1:0]     r_cnt, n_cnt;
    logic [LB_BITS-1:0]     r_idx, n_idx;
    logic                   r_dup, n_dup;
    logic                   r_merge, n_merge;
    logic [SLOT_BITS-1:0]   r_target, n_target;
    logic [2:0][BYTE_BITS-1:0] r_nb, n_nb;
    logic                   r_out_valid, n_out_valid;
    t_rsp                   r_rsp, n_rsp;

    logic                   rd_en;
    logic [SLOT_BITS-1:0]   rd_addr;
    logic                   wr_en;
    logic                   accept;
    logic                   fin_fire;
    logic [LB_BITS-1:0]     start_cnt;

    logic [PREFIX_BITS-1:0] e_prefix;
    logic [BYTE_BITS-1:0]   e_b1, e_b2, e_b3;
    logic                   e_dup, e_merge;
    logic [2:0][BYTE_BITS-1:0] e_nb;
    logic [SLOT_BITS-1:0]   s_cur;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && (r_state == S_IDLE);
    assign fin_fire    = (r_state == S_FIN) && (!r_out_valid || o_rsp.ready);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_rsp;

    assign start_cnt = (r_live >= COUNT_BITS'(LOOKBEHIND)) ? LB_BITS'(LOOKBEHIND)
                                                           : r_live[LB_BITS-1:0];

    // compare one lookbehind slot against the pending insert
    assign e_prefix = r_rd_data[ENTRY_BITS-1:3*BYTE_BITS];
    assign e_b3     = r_rd_data[3*BYTE_BITS-1:2*BYTE_BITS];
    assign e_b2     = r_rd_data[2*BYTE_BITS-1:BYTE_BITS];
    assign e_b1     = r_rd_data[BYTE_BITS-1:0];
    assign s_cur    = r_write_slot - SLOT_BITS'(r_idx);

    always_comb begin
        e_dup   = 1'b0;
        e_merge = 1'b0;
        e_nb    = r_nb;
        if (e_prefix == r_prefix) begin
            priority if (r_byte == e_b1) begin
                e_dup = 1'b1;
            end else if (r_byte == e_b2) begin
                if (r_byte != '0) begin
                    e_dup = 1'b1;
                end else begin
                    e_merge = 1'b1;
                    e_nb    = {e_b3, e_b1, r_byte};
                end
            end else if (e_b2 == '0) begin
                e_merge = 1'b1;
                e_nb    = {e_b3, r_byte, e_b1};
            end else if (r_byte == e_b3) begin
                if (r_byte != '0) begin
                    e_dup = 1'b1;
                end else begin
                    e_merge = 1'b1;
                    e_nb    = {e_b1, e_b2, r_byte};
                end
            end else if (e_b3 == '0) begin
                e_merge = 1'b1;
                e_nb    = {r_byte, e_b2, e_b1};
            end else begin
                // full slot is skipped
                e_merge = 1'b0;
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_write_slot = r_write_slot;
        n_oldest     = r_oldest;
        n_live       = r_live;
        n_kind       = r_kind;
        n_prefix     = r_prefix;
        n_byte       = r_byte;
        n_cnt        = r_cnt;
        n_idx        = r_idx;
        n_dup        = r_dup;
        n_merge      = r_merge;
        n_target     = r_target;
        n_nb         = r_nb;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_rsp        = r_rsp;
        rd_en        = 1'b0;
        rd_addr      = r_oldest;
        wr_en        = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_kind   = i_req.data.kind;
                    n_prefix = i_req.data.pointer_address[ADDRESS_BITS-1:BYTE_BITS];
                    n_byte   = i_req.data.pointer_address[BYTE_BITS-1:0];
                    n_dup    = 1'b0;
                    n_merge  = 1'b0;
                    n_target = r_write_slot;
                    n_nb     = {BYTE_BITS'(0), BYTE_BITS'(0),
                                i_req.data.pointer_address[BYTE_BITS-1:0]};
                    n_cnt    = start_cnt;
                    n_idx    = LB_BITS'(1);
                    if (i_req.data.kind == KIND_INSERT) begin
                        if (start_cnt == '0) begin
                            n_state = S_FIN;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = r_write_slot - SLOT_BITS'(1);
                            n_state = S_SCAN;
                        end
                    end else begin
                        rd_en   = (r_live != '0);
                        rd_addr = r_oldest;
                        n_state = S_FIN;
                    end
                end
            end
            S_SCAN: begin
                if (e_dup) begin
                    n_dup    = 1'b1;
                    n_target = s_cur;
                end else if (e_merge) begin
                    n_merge  = 1'b1;
                    n_target = s_cur;
                    n_nb     = e_nb;
                end
                if (e_dup || (r_idx == r_cnt)) begin
                    n_state = S_FIN;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_write_slot - SLOT_BITS'(r_idx + LB_BITS'(1));
                    n_idx   = r_idx + LB_BITS'(1);
                end
            end
            S_FIN: begin
                if (fin_fire) begin
                    n_rsp                   = '0;
                    if (r_kind == KIND_INSERT) begin
                        n_rsp.slot = r_target;
                        if (r_dup) begin
                            n_rsp.outcome = OC_DUPLICATE;
                        end else begin
                            wr_en = 1'b1;
                            if (r_merge) begin
                                n_rsp.outcome = OC_MERGED;
                            end else begin
                                n_rsp.outcome = OC_NEW_SLOT;
                                n_write_slot  = r_write_slot + SLOT_BITS'(1);
                                if (r_live >= COUNT_BITS'(LOG_DEPTH)) begin
                                    n_oldest = r_oldest + SLOT_BITS'(1);
                                end else begin
                                    n_live = r_live + COUNT_BITS'(1);
                                end
                            end
                        end
                    end else if (r_live == '0) begin
                        n_rsp.outcome = OC_EMPTY;
                    end else begin
                        n_rsp.outcome = OC_POPPED;
                        n_rsp.slot    = r_oldest;
                        if (e_prefix != '0) begin
                            n_rsp.first_pointer     = {e_prefix, e_b1};
                            n_rsp.pointers_returned = NRET_BITS'(1);
                            if (e_b2 != '0) begin
                                n_rsp.second_pointer    = {e_prefix, e_b2};
                                n_rsp.pointers_returned = NRET_BITS'(2);
                                if (e_b3 != '0) begin
                                    n_rsp.third_pointer     = {e_prefix, e_b3};
                                    n_rsp.pointers_returned = NRET_BITS'(3);
                                end
                            end
                        end
                        n_oldest = r_oldest + SLOT_BITS'(1);
                        n_live   = r_live - COUNT_BITS'(1);
                    end
                    n_rsp.live_slots     = n_live;
                    n_rsp.over_threshold = (n_live >= COUNT_BITS'(r_thr));
                    n_out_valid          = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (wr_en) begin
            r_mem[r_target] <= {r_prefix, r_nb};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_write_slot <= '0;
            r_oldest     <= '0;
            r_live       <= '0;
            r_thr        <= THR_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_write_slot <= n_write_slot;
            r_oldest     <= n_oldest;
            r_live       <= n_live;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_prefix <= n_prefix;
        r_byte   <= n_byte;
        r_cnt    <= n_cnt;
        r_idx    <= n_idx;
        r_dup    <= n_dup;
        r_merge  <= n_merge;
        r_target <= n_target;
        r_nb     <= n_nb;
        r_rsp    <= n_rsp;
    end

    `CPL_ASSERT_NOW(a_live_bound, i_clk, i_rst_n, 1'b1,
        r_live <= COUNT_BITS'(LOG_DEPTH), "live slot count above log depth")
    `CPL_ASSERT_NOW(a_ring_consistent, i_clk, i_rst_n, 1'b1,
        r_write_slot == SLOT_BITS'(r_oldest + r_live[SLOT_BITS-1:0]),
        "write and oldest slot pointers disagree with live count")
    `CPL_ASSERT_NOW(a_scan_index, i_clk, i_rst_n, r_state == S_SCAN,
        (r_idx != '0) && (r_idx <= r_cnt), "lookbehind index out of range")
    `CPL_ASSERT_NEXT(a_fin_response, i_clk, i_rst_n, fin_fire,
        o_rsp.valid && (r_state == S_IDLE), "finished request left no response")

endmodule
